// File: design/prcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prcb_pkg: shared types and constants for the palette recolor block
// Holds the item field types, operation and register codes, and the color-box
// quantization helpers.
// ----------------------------------------------------------------------------
package prcb_pkg;

    typedef logic [31:0] t_color;
    typedef logic [7:0]  t_chan;
    typedef logic [5:0]  t_entry_idx;
    typedef logic [6:0]  t_entry_cnt;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef enum logic {
        CFG_USE_COLOR_BOX = 1'b0,
        CFG_ENTRIES_USED  = 1'b1
    } t_cfg_reg;

    localparam int    CFG_DATA_W = 7;
    localparam t_chan BOX_SIZE   = 8'd43;
    localparam t_chan CHAN_MAX   = 8'd255;

    // Rounds one channel down to a multiple of the box size.
    function automatic t_chan box_chan(input t_chan c);
        t_chan r;
        if (c >= 8'(5 * BOX_SIZE)) begin
            r = 8'(5 * BOX_SIZE);
        end else if (c >= 8'(4 * BOX_SIZE)) begin
            r = 8'(4 * BOX_SIZE);
        end else if (c >= 8'(3 * BOX_SIZE)) begin
            r = 8'(3 * BOX_SIZE);
        end else if (c >= 8'(2 * BOX_SIZE)) begin
            r = 8'(2 * BOX_SIZE);
        end else if (c >= BOX_SIZE) begin
            r = BOX_SIZE;
        end else begin
            r = 8'd0;
        end
        return r;
    endfunction

    // Alpha is kept, R, G and B are quantized.
    function automatic t_color box_of(input t_color c);
        return {c[31:24], box_chan(c[23:16]), box_chan(c[15:8]), box_chan(c[7:0])};
    endfunction

endpackage

// File: design/prcb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prcb_if: channel interfaces of the palette recolor block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface prcb_in_if;
    logic                 valid;
    logic                 ready;
    prcb_pkg::t_op        operation;
    prcb_pkg::t_entry_idx entry_index;
    prcb_pkg::t_color     key_color;
    prcb_pkg::t_color     new_color;
    prcb_pkg::t_color     pixel_in;

    modport source (output valid, operation, entry_index, key_color, new_color, pixel_in,
                    input ready);
    modport sink   (input valid, operation, entry_index, key_color, new_color, pixel_in,
                    output ready);
endinterface

interface prcb_out_if;
    logic             valid;
    logic             ready;
    prcb_pkg::t_color pixel_out;
    logic             matched;

    modport source (output valid, pixel_out, matched, input ready);
    modport sink   (input valid, pixel_out, matched, output ready);
endinterface

interface prcb_cfg_if;
    logic                            valid;
    logic                            ready;
    prcb_pkg::t_cfg_reg              reg_index;
    logic [prcb_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: design/palette_recolor_with_color_box_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_recolor_with_color_box_core: palette recolor with color-box match
// Pipelined palette lookup: parallel key compares, registered first-match
// tree, replacement memory read and per-channel recolor.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries load items (write one palette entry) and pixel items.
//   o_pix returns one result item per pixel item; load items return nothing.
//   i_cfg writes use_color_box (index 0) and entries_used (index 1); it is
//   always ready; the user ensures it is written only while no item is in flight.
// Throughput: one item per cycle. Every stage is a register and the whole
//   pipeline advances together, so the only limit is the output handshake.
// A pixel item passes six register stages before its result shows on
//   o_pix: input capture, key compare row, group priority encode, final
//   priority encode, replacement memory read, recolor into the output
//   register.
// A load item writes the key cells when it leaves the first stage and the
//   replacement memory when it reaches the read stage, so items on either
//   side of it see the table in stream order.
// Reset clears the stage valid bits and config registers; the palette is not
//   cleared and an entry must be loaded before a pixel can match it.
// When o_pix.ready is low with a result waiting, all stages hold and
//   i_pix.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module palette_recolor_with_color_box_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prcb_in_if.sink       i_pix,
    prcb_out_if.source    o_pix,
    prcb_cfg_if.sink      i_cfg
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int NGRP   = (TABLE_ENTRIES + 7) / 8;
    localparam int HIT_W  = NGRP * 8;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int GIDX_W = GRP_W + 3;
    localparam logic [8:0] TE_W = 9'(TABLE_ENTRIES);

    // Configuration registers
    logic                 r_use_box;
    prcb_pkg::t_entry_cnt r_entries_used;
    logic [8:0]           w_cnt;

    // Pipeline control
    logic w_en;

    // Stage 1: captured item
    logic               r_s1_valid;
    prcb_pkg::t_op      r_s1_op;
    logic               r_s1_wok;
    logic [IDX_W-1:0]   r_s1_widx;
    prcb_pkg::t_color   r_s1_key;
    prcb_pkg::t_color   r_s1_repl;
    prcb_pkg::t_color   r_s1_pix;
    prcb_pkg::t_color   r_s1_box;

    // Palette key cells
    prcb_pkg::t_color   r_key  [TABLE_ENTRIES];
    prcb_pkg::t_color   r_kbox [TABLE_ENTRIES];
    logic               w_cell_wr;
    logic [HIT_W-1:0]   w_hit;

    // Stage 2: compare row
    logic               r_s2_valid;
    prcb_pkg::t_op      r_s2_op;
    logic               r_s2_wok;
    logic [IDX_W-1:0]   r_s2_widx;
    prcb_pkg::t_color   r_s2_repl;
    prcb_pkg::t_color   r_s2_pix;
    prcb_pkg::t_color   r_s2_box;
    logic [HIT_W-1:0]   r_s2_hit;

    // Stage 3: per-group first match
    logic [NGRP-1:0]    w_grp_hit;
    logic [2:0]         w_loc [NGRP];
    logic               r_s3_valid;
    prcb_pkg::t_op      r_s3_op;
    logic               r_s3_wok;
    logic [IDX_W-1:0]   r_s3_widx;
    prcb_pkg::t_color   r_s3_repl;
    prcb_pkg::t_color   r_s3_pix;
    prcb_pkg::t_color   r_s3_box;
    logic [NGRP-1:0]    r_s3_grp_hit;
    logic [2:0]         r_s3_loc [NGRP];

    // Stage 4: first match over all groups
    logic [GIDX_W-1:0]  w_gidx;
    logic               r_s4_valid;
    prcb_pkg::t_op      r_s4_op;
    logic               r_s4_wok;
    logic [IDX_W-1:0]   r_s4_addr;
    prcb_pkg::t_color   r_s4_repl;
    prcb_pkg::t_color   r_s4_pix;
    prcb_pkg::t_color   r_s4_box;
    logic               r_s4_hit;

    // Stage 5: replacement memory read
    prcb_pkg::t_color   r_repl_mem [TABLE_ENTRIES];
    logic               r_s5_valid;
    prcb_pkg::t_op      r_s5_op;
    prcb_pkg::t_color   r_s5_repl;
    prcb_pkg::t_color   r_s5_pix;
    prcb_pkg::t_color   r_s5_box;
    logic               r_s5_hit;

    // Output stage
    prcb_pkg::t_color   w_blend;
    prcb_pkg::t_color   n_out_pixel;
    logic               r_out_valid;
    prcb_pkg::t_color   r_out_pixel;
    logic               r_out_matched;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_box      <= 1'b0;
            r_entries_used <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                prcb_pkg::CFG_USE_COLOR_BOX: r_use_box      <= i_cfg.wr_data[0];
                prcb_pkg::CFG_ENTRIES_USED:  r_entries_used <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Entry count saturated to the table depth.
    assign w_cnt = ({2'b00, r_entries_used} > TE_W) ? TE_W : {2'b00, r_entries_used};

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together.
    // ------------------------------------------------------------------
    assign w_en        = !r_out_valid || o_pix.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_pix.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid && (r_s5_op == prcb_pkg::OP_PIXEL);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture and quantize the key (load) or the pixel (pixel item)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op   <= i_pix.operation;
            r_s1_wok  <= {3'b000, i_pix.entry_index} < TE_W;
            r_s1_widx <= IDX_W'(i_pix.entry_index);
            r_s1_key  <= i_pix.key_color;
            r_s1_repl <= i_pix.new_color;
            r_s1_pix  <= i_pix.pixel_in;
            r_s1_box  <= prcb_pkg::box_of((i_pix.operation == prcb_pkg::OP_PIXEL) ?
                                          i_pix.pixel_in : i_pix.key_color);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: key cells and the compare row
    // ------------------------------------------------------------------
    assign w_cell_wr = w_en && r_s1_valid && (r_s1_op == prcb_pkg::OP_LOAD) && r_s1_wok;

    for (genvar gi = 0; gi < HIT_W; gi++) begin : g_cell
        if (gi < TABLE_ENTRIES) begin : g_used
            always_ff @(posedge i_clk) begin
                if (w_cell_wr && (r_s1_widx == IDX_W'(gi))) begin
                    r_key[gi]  <= r_s1_key;
                    r_kbox[gi] <= r_s1_box;
                end
            end

            assign w_hit[gi] = (9'(gi) < w_cnt) &&
                               (r_use_box ? (r_kbox[gi] == r_s1_box) : (r_key[gi] == r_s1_pix));
        end else begin : g_pad
            assign w_hit[gi] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_wok  <= r_s1_wok;
            r_s2_widx <= r_s1_widx;
            r_s2_repl <= r_s1_repl;
            r_s2_pix  <= r_s1_pix;
            r_s2_box  <= r_s1_box;
            r_s2_hit  <= (r_s1_op == prcb_pkg::OP_PIXEL) ? w_hit : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: lowest matching entry inside each group of eight
    // ------------------------------------------------------------------
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_hit[g] = |r_s2_hit[g*8 +: 8];
            w_loc[g]     = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (r_s2_hit[g*8 + j]) begin
                    w_loc[g] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_op      <= r_s2_op;
            r_s3_wok     <= r_s2_wok;
            r_s3_widx    <= r_s2_widx;
            r_s3_repl    <= r_s2_repl;
            r_s3_pix     <= r_s2_pix;
            r_s3_box     <= r_s2_box;
            r_s3_grp_hit <= w_grp_hit;
            r_s3_loc     <= w_loc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: lowest matching group; a load item keeps its write address
    // ------------------------------------------------------------------
    always_comb begin
        w_gidx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_s3_grp_hit[g]) begin
                w_gidx = {GRP_W'(g), r_s3_loc[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_op   <= r_s3_op;
            r_s4_wok  <= r_s3_wok;
            r_s4_addr <= (r_s3_op == prcb_pkg::OP_LOAD) ? r_s3_widx : IDX_W'(w_gidx);
            r_s4_repl <= r_s3_repl;
            r_s4_pix  <= r_s3_pix;
            r_s4_box  <= r_s3_box;
            r_s4_hit  <= |r_s3_grp_hit;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: replacement memory, written and read at this one stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_s4_valid && (r_s4_op == prcb_pkg::OP_LOAD) && r_s4_wok) begin
                r_repl_mem[r_s4_addr] <= r_s4_repl;
            end
            r_s5_repl <= r_repl_mem[r_s4_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_op  <= r_s4_op;
            r_s5_pix <= r_s4_pix;
            r_s5_box <= r_s4_box;
            r_s5_hit <= r_s4_hit;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: recolor and register the result item
    // ------------------------------------------------------------------
    always_comb begin
        logic [8:0] sum;
        w_blend[31:24] = r_s5_pix[31:24];
        for (int c = 0; c < 3; c++) begin
            // The pixel's offset inside its box is added to the replacement.
            sum = {1'b0, r_s5_repl[c*8 +: 8]} +
                  {1'b0, r_s5_pix[c*8 +: 8] - r_s5_box[c*8 +: 8]};
            w_blend[c*8 +: 8] = sum[8] ? prcb_pkg::CHAN_MAX : sum[7:0];
        end
    end

    always_comb begin
        if (!r_s5_hit) begin
            n_out_pixel = r_s5_pix;
        end else if (r_use_box) begin
            n_out_pixel = w_blend;
        end else begin
            n_out_pixel = r_s5_repl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pixel   <= n_out_pixel;
            r_out_matched <= r_s5_hit;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_out = r_out_pixel;
    assign o_pix.matched   = r_out_matched;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pixel_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s5_valid && (r_s5_op == prcb_pkg::OP_PIXEL)) |=> o_pix.valid)
        else $error("pixel item in the read stage produced no result item");

    a_row_to_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s2_valid && (|r_s2_hit)) |=> (|r_s3_grp_hit))
        else $error("compare row hit was lost in the group encoder");

    a_group_to_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s3_valid && (|r_s3_grp_hit)) |=> r_s4_hit)
        else $error("group hit was lost in the final encoder");

    a_load_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && (r_s2_op == prcb_pkg::OP_LOAD)) |-> (r_s2_hit == '0))
        else $error("load item carries a match");

    a_hit_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && r_s4_hit) |-> (w_cnt != 9'd0))
        else $error("match reported with no entries searched");

endmodule

// File: verif/prcb_recolor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prcb_recolor_checker: scoreboard for the palette recolor block
// Watches the pixel, result and register channels at the rising clock edge,
// keeps its own copy of the palette and registers, predicts the result of
// every accepted pixel item and compares each result item in order.
// ----------------------------------------------------------------------------
module prcb_recolor_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    prcb_in_if   pix_in,
    prcb_out_if  pix_out,
    prcb_cfg_if  cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits
);

    localparam int BOX         = 43;
    localparam int CHAN_TOP    = 255;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        prcb_pkg::t_color pixel;
        logic             matched;
    } t_recolor;

    prcb_pkg::t_color     key_tbl  [TABLE_ENTRIES];
    prcb_pkg::t_color     box_tbl  [TABLE_ENTRIES];
    prcb_pkg::t_color     repl_tbl [TABLE_ENTRIES];
    logic                 box_mode;
    prcb_pkg::t_entry_cnt entries_used;
    t_recolor             pending_recolors [$];

    // Alpha stays, each color channel drops to the bottom of its box.
    function automatic prcb_pkg::t_color quantize(input prcb_pkg::t_color c);
        prcb_pkg::t_color q;
        int               k;
        q = c;
        for (k = 0; k < 3; k++) begin
            q[8*k +: 8] = 8'((int'(c[8*k +: 8]) / BOX) * BOX);
        end
        return q;
    endfunction

    function automatic prcb_pkg::t_color add_remainder(input prcb_pkg::t_color repl,
                                                       input prcb_pkg::t_color px);
        prcb_pkg::t_color r;
        int               k;
        int               s;
        r = px;
        for (k = 0; k < 3; k++) begin
            s = int'(repl[8*k +: 8]) + int'(px[8*k +: 8]) % BOX;
            r[8*k +: 8] = (s > CHAN_TOP) ? 8'(CHAN_TOP) : 8'(s);
        end
        return r;
    endfunction

    function automatic t_recolor recolor_pixel(input prcb_pkg::t_color px);
        t_recolor         r;
        prcb_pkg::t_color pbox;
        int               lim;
        int               i;
        r.pixel   = px;
        r.matched = 1'b0;
        pbox      = quantize(px);
        lim       = (int'(entries_used) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_used);
        for (i = 0; i < lim; i++) begin
            if (!r.matched) begin
                if (box_mode ? (box_tbl[i] == pbox) : (key_tbl[i] == px)) begin
                    r.matched = 1'b1;
                    r.pixel   = box_mode ? add_remainder(repl_tbl[i], px) : repl_tbl[i];
                end
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_recolor got;
        t_recolor want;
        if (!i_rst_n) begin
            box_mode     = 1'b0;
            entries_used = '0;
            pending_recolors.delete();
        end else begin
            // Results are checked before new items are queued; the pipeline
            // never returns an item in the cycle it was accepted.
            if (pix_out.valid && pix_out.ready) begin
                got.pixel   = pix_out.pixel_out;
                got.matched = pix_out.matched;
                if (pending_recolors.size() == 0) begin
                    note_failure($sformatf("result pixel %08h matched %0b with no pixel pending",
                                           got.pixel, got.matched));
                end else begin
                    want = pending_recolors.pop_front();
                    o_checked++;
                    if (want.matched) begin
                        o_hits++;
                    end
                    if (want.pixel !== got.pixel || want.matched !== got.matched) begin
                        note_failure($sformatf(
                            "result %0d: expected %08h/%0b, got %08h/%0b (pixel/matched)",
                            o_checked, want.pixel, want.matched, got.pixel, got.matched));
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.reg_index)
                    prcb_pkg::CFG_USE_COLOR_BOX: box_mode = cfg.wr_data[0];
                    prcb_pkg::CFG_ENTRIES_USED:  entries_used = cfg.wr_data;
                    default: ;
                endcase
            end
            if (pix_in.valid && pix_in.ready) begin
                if (pix_in.operation == prcb_pkg::OP_LOAD) begin
                    if (int'(pix_in.entry_index) < TABLE_ENTRIES) begin
                        key_tbl[pix_in.entry_index]  = pix_in.key_color;
                        box_tbl[pix_in.entry_index]  = quantize(pix_in.key_color);
                        repl_tbl[pix_in.entry_index] = pix_in.new_color;
                    end
                end else begin
                    pending_recolors.push_back(recolor_pixel(pix_in.pixel_in));
                end
            end
        end
        o_pending = pending_recolors.size();
    end

endmodule

// File: verif/palette_recolor_with_color_box_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_recolor_with_color_box_core_tb: top of the palette recolor testbench
// Drives palette loads, pixels and register writes into the block with random
// gaps and result stalls, and gives the verdict from the scoreboard's count.
// A directed opening covers pass-through, exact and box matches, first-match
// priority and saturation; random phases then sweep both modes and entry
// counts up to the register's maximum.
// ----------------------------------------------------------------------------
module palette_recolor_with_color_box_core_tb;

    localparam int TABLE_ENTRIES = 64;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 42;
    localparam int KEY_POOL      = 16;

    logic i_clk;
    logic i_rst_n;

    prcb_in_if  pix_if();
    prcb_out_if res_if();
    prcb_cfg_if cfg_if();

    int               fail_count;
    int               pending;
    int               checked;
    int               hits;
    bit               calm;
    int               n_loads;
    int               n_pixels;
    int               n_settings;
    prcb_pkg::t_color key_mirror [TABLE_ENTRIES];
    prcb_pkg::t_color key_pool   [KEY_POOL];

    palette_recolor_with_color_box_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .o_pix  (res_if),
        .i_cfg  (cfg_if)
    );

    prcb_recolor_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_recolor_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pix_in      (pix_if),
        .pix_out     (res_if),
        .cfg         (cfg_if),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_hits      (hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Run stopped at the cycle limit of %0d.", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Mostly short waits, now and then a long one.
    function automatic int short_or_long();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic prcb_pkg::t_color pick_key();
        if ($urandom_range(0, 3) != 0) begin
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        end
        return $urandom;
    endfunction

    initial begin
        res_if.ready = 1'b1;
        forever begin
            if (calm || $urandom_range(0, 99) < 60) begin
                res_if.ready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b0;
                repeat (short_or_long()) @(negedge i_clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input prcb_pkg::t_op op, input prcb_pkg::t_entry_idx idx,
                             input prcb_pkg::t_color key, input prcb_pkg::t_color repl,
                             input prcb_pkg::t_color pix);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : short_or_long();
        if (gap > 0) begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.operation   = op;
        pix_if.entry_index = idx;
        pix_if.key_color   = key;
        pix_if.new_color   = repl;
        pix_if.pixel_in    = pix;
        pix_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        if (op == prcb_pkg::OP_LOAD) begin
            key_mirror[idx] = key;
            n_loads++;
        end else begin
            n_pixels++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_load(input prcb_pkg::t_entry_idx idx, input prcb_pkg::t_color key,
                             input prcb_pkg::t_color repl);
        send_item(prcb_pkg::OP_LOAD, idx, key, repl, $urandom);
    endtask

    task automatic send_pixel(input prcb_pkg::t_color pix);
        send_item(prcb_pkg::OP_PIXEL, prcb_pkg::t_entry_idx'($urandom), $urandom, $urandom,
                  pix);
    endtask

    task automatic write_reg(input prcb_pkg::t_cfg_reg idx,
                             input logic [prcb_pkg::CFG_DATA_W-1:0] data);
        cfg_if.reg_index = idx;
        cfg_if.wr_data   = data;
        cfg_if.valid     = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Load items leave no result behind, so a settle wait covers them.
    task automatic drain();
        pix_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic box, input prcb_pkg::t_entry_cnt used);
        drain();
        write_reg(prcb_pkg::CFG_USE_COLOR_BOX, {6'($urandom), box});
        write_reg(prcb_pkg::CFG_ENTRIES_USED, used);
        n_settings++;
    endtask

    initial begin
        int                   used;
        int                   lim;
        int                   sel;
        int                   k;
        int                   base;
        int                   top_v;
        prcb_pkg::t_entry_idx idx;
        prcb_pkg::t_color     px;

        i_rst_n            = 1'b0;
        calm               = 1'b1;
        pix_if.valid       = 1'b0;
        pix_if.operation   = prcb_pkg::OP_LOAD;
        pix_if.entry_index = '0;
        pix_if.key_color   = '0;
        pix_if.new_color   = '0;
        pix_if.pixel_in    = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.reg_index   = prcb_pkg::CFG_USE_COLOR_BOX;
        cfg_if.wr_data     = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // No entries searched yet: everything passes through.
        set_mode(1'b0, 7'd0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_load(6'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_load(6'd1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_load(6'd2, 32'h802B_56D7, 32'h11FF_F000);
        send_load(6'd3, 32'h402A_54FF, 32'h2210_2030);
        send_load(6'd4, 32'h402A_54FF, 32'h3344_5566);
        send_load(6'd5, 32'hFF12_3456, 32'hA55A_C33C);
        send_pixel(32'h402A_54FF);

        // Exact mode; entries 3 and 4 share a key, so entry 3 must win.
        set_mode(1'b0, 7'd6);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h402A_54FF);
        send_pixel(32'h402A_54FE);
        send_load(6'd2, 32'h0102_0304, 32'h0A0B_0C0D);
        send_pixel(32'h0102_0304);
        send_pixel(32'hFF12_3456);

        // Box mode: identical keys, off-box remainders, saturation, alpha miss.
        set_mode(1'b1, 7'd6);
        send_pixel(32'hFF12_3456);
        send_pixel(32'h402A_54FF);
        send_pixel(32'h4000_2BFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h002A_2A2A);
        send_pixel(32'h7F2A_2A2A);

        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        // Every entry is written before any count can reach it.
        calm = 1'b0;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            send_load(prcb_pkg::t_entry_idx'(e), pick_key(), $urandom);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       used = 64;
                1:       used = 127;
                2:       used = 0;
                3:       used = 1;
                4:       used = 65;
                5:       used = $urandom_range(2, 63);
                6:       used = $urandom_range(2, 127);
                7:       used = 64;
                default: used = $urandom_range(1, 12);
            endcase
            set_mode((p < 4) ? 1'(p % 2) : 1'($urandom_range(0, 1)), 7'(used));
            calm = ($urandom_range(0, 3) == 0);
            lim  = (used > TABLE_ENTRIES) ? TABLE_ENTRIES : used;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    calm = !calm;
                end
                idx = (lim == 0)
                    ? prcb_pkg::t_entry_idx'($urandom_range(0, TABLE_ENTRIES - 1))
                    : prcb_pkg::t_entry_idx'($urandom_range(0, lim - 1));
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    send_load(prcb_pkg::t_entry_idx'($urandom), pick_key(), $urandom);
                end else if (sel < 50) begin
                    send_pixel(key_mirror[idx]);
                end else if (sel < 80) begin
                    // Same box as a searched key, with a random remainder.
                    px = key_mirror[idx];
                    for (k = 0; k < 3; k++) begin
                        base  = (int'(px[8*k +: 8]) / 43) * 43;
                        top_v = (base + 42 > 255) ? 255 : base + 42;
                        px[8*k +: 8] = 8'($urandom_range(base, top_v));
                    end
                    send_pixel(px);
                end else begin
                    send_pixel($urandom);
                end
            end
        end

        drain();
        $display("Run covered %0d load items and %0d pixel items over %0d register settings.",
                 n_loads, n_pixels, n_settings);
        $display("Both modes, entry counts 0 to 127: %0d results checked, %0d hits, %0d errors.",
                 checked, hits, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
